// ===== rtl/jcp_pkg.sv =====
// ----------------------------------------------------------------------------
// jcp_pkg
// Shared widths, angle constants and the arctangent table for the joystick
// cartesian-to-polar converter.
// ----------------------------------------------------------------------------
package jcp_pkg;

  localparam int AXIS_BITS    = 16;
  localparam int CORDIC_STEPS = 32;
  localparam int PRE_SHIFT    = 30;

  // CORDIC vector width: axis, pre-scale, gain and sign headroom
  localparam int CW = AXIS_BITS + PRE_SHIFT + 3;
  // Angle accumulator width in 2^-32 turn, with room for the wrap math
  localparam int ZW = 36;
  localparam int ANG_BITS  = 32;
  localparam int HEAD_BITS = 9;
  localparam int MAG_BITS  = 16;
  localparam int PW        = ANG_BITS + HEAD_BITS;

  localparam int SQ_BITS   = 2 * AXIS_BITS;
  localparam int ROOT_BITS = AXIS_BITS;

  // Stage count: input, CORDIC steps, wrap, scale/output
  localparam int NSTAGE    = CORDIC_STEPS + 3;
  // Magnitude is ready after the sum and the root steps; pad up to the output
  localparam int MAG_DELAY = NSTAGE - 2 - ROOT_BITS;

  localparam logic signed [ZW-1:0] TURN_QUARTER = ZW'(64'sd1 << 30);
  localparam logic signed [ZW-1:0] TURN_HALF    = ZW'(64'sd1 << 31);
  localparam logic signed [ZW-1:0] TURN_FULL    = ZW'(64'sd1 << 32);

  localparam logic [HEAD_BITS-1:0] HEADING_SCALE = HEAD_BITS'(360);
  localparam logic [PW-1:0]        ROUND_HALF    = PW'(64'd1 << 31);

  // atan(2^-i) in 2^-32 turn
  localparam logic [0:CORDIC_STEPS-1][31:0] ARC_TABLE = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ===== rtl/joystick_cartesian_to_polar.sv =====
// ----------------------------------------------------------------------------
// joystick_cartesian_to_polar
// Turns a signed joystick sample into a heading in whole degrees and a length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, axis_x, axis_y) takes one sample per
//   item. Output channel (out_valid/out_ready, heading_deg, magnitude) gives
//   one result per item, in order. heading_deg is atan2(x, y) - 90 degrees,
//   wrapped to 0..360 and rounded; magnitude is floor(sqrt(x^2 + y^2)).
//   From acceptance to out_valid an item passes an input stage, 32
//   CORDIC stages, a wrap stage and the scale/output stage. The square root
//   runs alongside in 17 stages and is padded to match.
//   Throughput is one item per clock while out_ready keeps up; the pipeline length sets the latency.
//   When out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated. Empty stages ahead of the
//   output do not hold the input back while the output register is empty.
//   Reset clears all valid bits; no results are pending afterwards.
// ----------------------------------------------------------------------------
module joystick_cartesian_to_polar import jcp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [AXIS_BITS-1:0] axis_x,
  input  logic signed [AXIS_BITS-1:0] axis_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [HEAD_BITS-1:0]        heading_deg,
  output logic [MAG_BITS-1:0]         magnitude
);

  logic en;
  logic vld [NSTAGE];

  assign en        = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTAGE; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < NSTAGE; s++) vld[s] <= vld[s-1];
    end
  end

  // Input stage: axis cases, half-plane fold, pre-scale, squares
  logic signed [CW-1:0] x_ext, y_ext, re_pre, im_pre;
  logic signed [ZW-1:0] z_pre;
  logic                 fixed_pre;
  logic                 x_zero, y_zero, x_pos, y_pos;

  assign x_ext  = CW'(axis_x);
  assign y_ext  = CW'(axis_y);
  assign x_zero = (axis_x == '0);
  assign y_zero = (axis_y == '0);
  assign x_pos  = !axis_x[AXIS_BITS-1] && !x_zero;
  assign y_pos  = !axis_y[AXIS_BITS-1] && !y_zero;

  always_comb begin
    fixed_pre = 1'b1;
    re_pre    = '0;
    im_pre    = '0;
    z_pre     = '0;
    if (x_zero && y_zero) begin
      z_pre = '0;
    end else if (x_zero) begin
      z_pre = y_pos ? '0 : TURN_HALF;
    end else if (y_zero) begin
      z_pre = x_pos ? TURN_QUARTER : -TURN_QUARTER;
    end else begin
      fixed_pre = 1'b0;
      if (axis_y[AXIS_BITS-1]) begin
        // fold the left half-plane onto the right
        z_pre  = x_pos ? TURN_HALF : -TURN_HALF;
        re_pre = (-y_ext) <<< PRE_SHIFT;
        im_pre = (-x_ext) <<< PRE_SHIFT;
      end else begin
        re_pre = y_ext <<< PRE_SHIFT;
        im_pre = x_ext <<< PRE_SHIFT;
      end
    end
  end

  logic signed [CW-1:0]    re0, im0;
  logic signed [ZW-1:0]    z0;
  logic                    fixed0;
  logic signed [SQ_BITS-1:0] xw, yw;
  logic [SQ_BITS-1:0]      sq_x, sq_y;

  assign xw = SQ_BITS'(axis_x);
  assign yw = SQ_BITS'(axis_y);

  always_ff @(posedge clk) begin
    if (en) begin
      re0    <= re_pre;
      im0    <= im_pre;
      z0     <= z_pre;
      fixed0 <= fixed_pre;
      sq_x   <= xw * xw;
      sq_y   <= yw * yw;
    end
  end

  logic signed [ZW-1:0] z_end;

  jcp_cordic u_cordic (
    .clk      (clk),
    .en       (en),
    .re_in    (re0),
    .im_in    (im0),
    .z_in     (z0),
    .fixed_in (fixed0),
    .z_out    (z_end)
  );

  // Wrap stage: subtract a quarter turn, wrap negative, clamp to one turn
  logic signed [ZW-1:0] a_off, a_wrap;
  logic [ANG_BITS-1:0]  a_clamp;
  logic [ANG_BITS-1:0]  angle;

  assign a_off  = z_end - TURN_QUARTER;
  assign a_wrap = a_off[ZW-1] ? a_off + TURN_FULL : a_off;

  always_comb begin
    if (a_wrap[ZW-1])             a_clamp = '0;
    else if (a_wrap >= TURN_FULL) a_clamp = '1;
    else                          a_clamp = a_wrap[ANG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) angle <= a_clamp;
  end

  // Scale stage: degrees = round(angle * 360 / 2^32)
  logic [PW-1:0] scaled;

  assign scaled = PW'(angle) * PW'(HEADING_SCALE) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) heading_deg <= scaled[ANG_BITS +: HEAD_BITS];
  end

  // Magnitude path
  logic [ROOT_BITS-1:0] root;
  logic [MAG_BITS-1:0]  mag_dly [MAG_DELAY];

  jcp_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .sq_a     (sq_x),
    .sq_b     (sq_y),
    .root_out (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mag_dly[0] <= MAG_BITS'(root);
      for (int s = 1; s < MAG_DELAY; s++) mag_dly[s] <= mag_dly[s-1];
    end
  end

  assign magnitude = mag_dly[MAG_DELAY-1];

endmodule

// ===== rtl/jcp_cordic.sv =====
// ----------------------------------------------------------------------------
// jcp_cordic
// Vectoring CORDIC, one rotation per register stage. Items marked fixed
// carry their angle through unchanged.
// ----------------------------------------------------------------------------
module jcp_cordic import jcp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] re_in,
  input  logic signed [CW-1:0] im_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic                 fixed_in,
  output logic signed [ZW-1:0] z_out
);

  logic signed [CW-1:0] re    [CORDIC_STEPS];
  logic signed [CW-1:0] im    [CORDIC_STEPS];
  logic signed [ZW-1:0] z     [CORDIC_STEPS+1];
  logic                 fixed [CORDIC_STEPS];

  assign re[0]    = re_in;
  assign im[0]    = im_in;
  assign z[0]     = z_in;
  assign fixed[0] = fixed_in;
  assign z_out    = z[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                 ccw;
    logic signed [ZW-1:0] arc;

    assign ccw = !im[i][CW-1] && (im[i] != '0);
    assign arc = ZW'(ARC_TABLE[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (fixed[i]) z[i+1] <= z[i];
        else if (ccw) z[i+1] <= z[i] + arc;
        else          z[i+1] <= z[i] - arc;
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          fixed[i+1] <= fixed[i];
          if (ccw) begin
            re[i+1] <= re[i] + (im[i] >>> i);
            im[i+1] <= im[i] - (re[i] >>> i);
          end else begin
            re[i+1] <= re[i] - (im[i] >>> i);
            im[i+1] <= im[i] + (re[i] >>> i);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/jcp_isqrt.sv =====
// ----------------------------------------------------------------------------
// jcp_isqrt
// Sum of two squares followed by a pipelined digit-by-digit square root,
// one root bit per stage.
// ----------------------------------------------------------------------------
module jcp_isqrt import jcp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_BITS-1:0]   sq_a,
  input  logic [SQ_BITS-1:0]   sq_b,
  output logic [ROOT_BITS-1:0] root_out
);

  localparam int RW = SQ_BITS + 1;

  logic [RW-1:0]        rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(sq_a) + RW'(sq_b);
      root[0] <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
    localparam int B = ROOT_BITS - 1 - k;
    logic [RW-1:0] trial;

    // (root + 2^B)^2 - root^2, root has no bits at or below B
    assign trial = (RW'(root[k]) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1]  <= rem[k] - trial;
          root[k+1] <= root[k] | (ROOT_BITS'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  assign root_out = root[ROOT_BITS];

endmodule
